FILE: src/kabf_pkg.sv
// Shared constants, types and saturation helpers for the angle/bias Kalman filter.
`default_nettype none
package kabf_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int COV_FRAC_BITS   = 32;
   localparam int GAIN_FRAC       = 30;
   localparam int NOISE_FRAC      = 24;
   localparam int TIME_FRAC       = 16;
   localparam int WRAP_LIMIT      = 90;

   localparam int SH_TIME  = TIME_FRAC;
   localparam int SH_GAIN  = GAIN_FRAC;
   localparam int SH_NOISE = NOISE_FRAC + TIME_FRAC - COV_FRAC_BITS;
   localparam int NC_LSH   = (COV_FRAC_BITS >= NOISE_FRAC) ? COV_FRAC_BITS - NOISE_FRAC : 0;
   localparam int NC_RSH   = (COV_FRAC_BITS >= NOISE_FRAC) ? 0 : NOISE_FRAC - COV_FRAC_BITS;

   localparam logic [1:0] CSR_ANGLE_NOISE = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE  = 2'd1;
   localparam logic [1:0] CSR_MEAS_NOISE  = 2'd2;
   localparam logic [1:0] CSR_WRAP_EN     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      STEP_ANG_PRED, STEP_T, STEP_P00_PRED, STEP_P11_PRED, STEP_ANG_CORR,
      STEP_BIAS_CORR, STEP_P10_CORR, STEP_P11_CORR, STEP_P00_CORR, STEP_P01_CORR
   } step_type;

   typedef enum logic [1:0] {SHIFT_TIME, SHIFT_GAIN, SHIFT_NOISE} shift_type;

   typedef struct packed {
      logic              start;
      logic signed [47:0] a;
      logic signed [32:0] b;
      shift_type         sh;
      logic              narrow;
   } mul_req_type;

   typedef struct packed {
      logic              start;
      logic signed [47:0] num;
      logic signed [47:0] den;
   } div_req_type;

   function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
      logic signed [51:0] hi;
      logic signed [51:0] lo;
      hi = 52'sh7FFFFFFFFFFF;
      lo = -hi - 52'sd1;
      if (v > hi) return hi[47:0];
      else if (v < lo) return lo[47:0];
      else return v[47:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [49:0] hi;
      logic signed [49:0] lo;
      hi = 50'sh7FFFFFFF;
      lo = -hi - 50'sd1;
      if (v > hi) return hi[31:0];
      else if (v < lo) return lo[31:0];
      else return v[31:0];
   endfunction

   function automatic logic signed [47:0] noise_to_cov(input logic [31:0] n);
      logic [63:0] v;
      v = ({32'd0, n} << NC_LSH) >> NC_RSH;
      if (v > 64'h7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
      else return $signed(v[47:0]);
   endfunction

endpackage
`default_nettype wire

FILE: src/kabf_mul.sv
// Shared multiplier: 16x32 per cycle, floor shift and saturation of the product.
`default_nettype none
module kabf_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kabf_pkg::mul_req_type mul_req,
   output logic                       mul_done,
   output logic signed [47:0]         mul_result
);

   logic [47:0]         a_ff, a_in;
   logic [31:0]         b_ff, b_in;
   logic                neg_ff, neg_in;
   logic [79:0]         acc_ff, acc_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   kabf_pkg::shift_type sh_ff, sh_in;
   logic                narrow_ff, narrow_in;
   logic                done_ff, done_in;
   logic signed [47:0]  res_ff, res_in;

   logic [6:0]  sh_amt;
   logic [79:0] q, mask, qi, lim, mag;
   logic        rem;

   always_comb begin
      case (sh_ff)
         kabf_pkg::SHIFT_TIME:  sh_amt = 7'(kabf_pkg::SH_TIME);
         kabf_pkg::SHIFT_GAIN:  sh_amt = 7'(kabf_pkg::SH_GAIN);
         kabf_pkg::SHIFT_NOISE: sh_amt = 7'(kabf_pkg::SH_NOISE);
         default:               sh_amt = 7'd0;
      endcase
      q    = acc_ff >> sh_amt;
      mask = (80'd1 << sh_amt) - 80'd1;
      rem  = |(acc_ff & mask);
      qi   = q + 80'(neg_ff & rem);
      lim  = (narrow_ff ? 80'h7FFFFFFF : 80'h7FFFFFFFFFFF) + 80'(neg_ff);
      mag  = (qi > lim) ? lim : qi;
   end

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      sh_in     = sh_ff;
      narrow_in = narrow_ff;
      done_in   = 1'b0;
      res_in    = res_ff;
      if (mul_req.start) begin
         a_in      = mul_req.a[47] ? 48'(-mul_req.a) : 48'(mul_req.a);
         b_in      = mul_req.b[32] ? 32'(-mul_req.b) : 32'(mul_req.b);
         neg_in    = mul_req.a[47] ^ mul_req.b[32];
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
         sh_in     = mul_req.sh;
         narrow_in = mul_req.narrow;
      end else if (busy_ff) begin
         if (cnt_ff == 2'd3) begin
            // round-down shift done, apply sign
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -$signed(mag[47:0]) : $signed(mag[47:0]);
         end else begin
            acc_in = (acc_ff << 16) + 80'(a_ff[47:32] * b_ff);
            a_in   = a_ff << 16;
            cnt_in = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      sh_ff     <= sh_in;
      narrow_ff <= narrow_in;
      res_ff    <= res_in;
   end

   assign mul_done   = done_ff;
   assign mul_result = res_ff;

endmodule
`default_nettype wire

FILE: src/kabf_div.sv
// Restoring divider producing a saturated Q1.30 gain, one quotient bit per cycle.
`default_nettype none
module kabf_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kabf_pkg::div_req_type div_req,
   output logic                       div_done,
   output logic signed [31:0]         div_quot
);

   logic [47:0]        un_ff, un_in;
   logic [47:0]        ud_ff, ud_in;
   logic               neg_ff, neg_in;
   logic               chk_ff, chk_in;
   logic               busy_ff, busy_in;
   logic [48:0]        rem_ff, rem_in;
   logic [30:0]        q_ff, q_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic signed [31:0] res_ff, res_in;

   logic        ge;
   logic [48:0] rem_sub;
   logic [30:0] q_next;

   always_comb begin
      ge      = rem_ff >= {1'b0, ud_ff};
      rem_sub = ge ? rem_ff - {1'b0, ud_ff} : rem_ff;
      q_next  = {q_ff[29:0], ge};
   end

   always_comb begin
      un_in   = un_ff;
      ud_in   = ud_ff;
      neg_in  = neg_ff;
      chk_in  = 1'b0;
      busy_in = busy_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (div_req.start) begin
         un_in  = div_req.num[47] ? 48'(-div_req.num) : 48'(div_req.num);
         ud_in  = div_req.den[47] ? 48'(-div_req.den) : 48'(div_req.den);
         neg_in = div_req.num[47] ^ div_req.den[47];
         chk_in = 1'b1;
      end else if (chk_ff) begin
         if (ud_ff == '0) begin
            done_in = 1'b1;
            res_in  = '0;
         end else if ({1'b0, un_ff} >= {ud_ff, 1'b0}) begin
            // quotient of two or more: clip to the gain range
            done_in = 1'b1;
            res_in  = neg_ff ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            busy_in = 1'b1;
            rem_in  = {1'b0, un_ff};
            q_in    = '0;
            cnt_in  = '0;
         end
      end else if (busy_ff) begin
         q_in   = q_next;
         rem_in = rem_sub << 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff  <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         chk_ff  <= chk_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      un_ff  <= un_in;
      ud_ff  <= ud_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      res_ff <= res_in;
   end

   assign div_done = done_ff;
   assign div_quot = res_ff;

endmodule
`default_nettype wire

FILE: src/kalman_angle_bias_filter.sv
// Top level of the one-axis angle/gyro-bias Kalman filter with its step sequencer.
`default_nettype none
//
//  channel   direction  handshake          payload
//  req       in         req_valid/stall    measured_angle, gyro_rate, time_step
//  rsp       out        rsp_valid/stall    filtered_angle, estimated_bias, wrap_jump
//  csr       in         csr_write_enable   csr_index, csr_write_data
//
//  A request runs from acceptance to rsp_valid through the wrap check, ten
//  products through the shared multiplier, two gain divisions (one quotient
//  bit per cycle; the divider ends early when the divisor is zero or the gain
//  clips) and the load of the output register. A wrap jump goes straight to the load.
//  req_stall is high from acceptance until the result is loaded into the
//  output register; a stalled result holds the next request at its last step.
//  Synchronous reset restores the noise registers and clears the estimates.
//
module kalman_angle_bias_filter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [24:0] req_measured_angle,
   input  wire logic signed [27:0] req_gyro_rate,
   input  wire logic [15:0]        req_time_step,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_filtered_angle,
   output logic signed [31:0]      rsp_estimated_bias,
   output logic                    rsp_wrap_jump,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_write_data
);

   kabf_pkg::state_type state_ff, state_in;
   kabf_pkg::step_type  step_ff, step_in;
   logic                ksel_ff, ksel_in;

   // request fields held for the whole update
   logic signed [24:0] z_ff, z_in;
   logic signed [27:0] w_ff, w_in;
   logic [15:0]        dt_ff, dt_in;

   // filter state
   logic signed [31:0] ang_ff, ang_in;
   logic signed [31:0] bias_ff, bias_in;
   logic signed [47:0] p00_ff, p00_in;
   logic signed [47:0] p01_ff, p01_in;
   logic signed [47:0] p10_ff, p10_in;
   logic signed [47:0] p11_ff, p11_in;

   // intermediates
   logic signed [47:0] inner_ff, inner_in;
   logic signed [31:0] k0_ff, k0_in;
   logic signed [31:0] k1_ff, k1_in;
   logic signed [31:0] y_ff, y_in;
   logic               jump_ff, jump_in;

   // configuration
   logic [31:0] apn_ff, apn_in;
   logic [31:0] bpn_ff, bpn_in;
   logic [31:0] mn_ff, mn_in;
   logic        wre_ff, wre_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_ang_ff, rsp_ang_in;
   logic signed [31:0] rsp_bias_ff, rsp_bias_in;
   logic               rsp_jump_ff, rsp_jump_in;

   kabf_pkg::mul_req_type mul_req;
   logic                  mul_done;
   logic signed [47:0]    mul_result;
   kabf_pkg::div_req_type div_req;
   logic                  div_done;
   logic signed [31:0]    div_quot;

   logic signed [47:0] nac, nmc, s_cov;
   logic signed [33:0] wrap_lim;
   logic signed [33:0] z34, a34;
   logic               wrap_hit;
   logic signed [32:0] dt33;

   kabf_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .mul_req    (mul_req),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

   kabf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   always_comb begin
      nac      = kabf_pkg::noise_to_cov(apn_ff);
      nmc      = kabf_pkg::noise_to_cov(mn_ff);
      // innovation variance
      s_cov    = kabf_pkg::sat48(52'(p00_ff) + 52'(nmc));
      wrap_lim = 34'(kabf_pkg::WRAP_LIMIT) <<< kabf_pkg::ANGLE_FRAC_BITS;
      z34      = 34'(z_ff);
      a34      = 34'(ang_ff);
      // measurement and estimate on opposite sides beyond +-90
      wrap_hit = wre_ff && ((z34 < -wrap_lim && a34 > wrap_lim) ||
                            (z34 > wrap_lim && a34 < -wrap_lim));
      dt33     = $signed({17'd0, dt_ff});
   end

   // multiplier operands per step
   always_comb begin
      mul_req.start  = (state_ff == kabf_pkg::ST_MUL_GO);
      mul_req.a      = '0;
      mul_req.b      = dt33;
      mul_req.sh     = kabf_pkg::SHIFT_TIME;
      mul_req.narrow = 1'b0;
      case (step_ff)
         kabf_pkg::STEP_ANG_PRED: begin
            mul_req.a      = 48'(kabf_pkg::sat32(50'(w_ff) - 50'(bias_ff)));
            mul_req.narrow = 1'b1;
         end
         kabf_pkg::STEP_T:        mul_req.a = p11_ff;
         kabf_pkg::STEP_P00_PRED: mul_req.a = inner_ff;
         kabf_pkg::STEP_P11_PRED: begin
            mul_req.a  = $signed({16'd0, bpn_ff});
            mul_req.sh = kabf_pkg::SHIFT_NOISE;
         end
         kabf_pkg::STEP_ANG_CORR: begin
            mul_req.a      = 48'(y_ff);
            mul_req.b      = 33'(k0_ff);
            mul_req.sh     = kabf_pkg::SHIFT_GAIN;
            mul_req.narrow = 1'b1;
         end
         kabf_pkg::STEP_BIAS_CORR: begin
            mul_req.a      = 48'(y_ff);
            mul_req.b      = 33'(k1_ff);
            mul_req.sh     = kabf_pkg::SHIFT_GAIN;
            mul_req.narrow = 1'b1;
         end
         kabf_pkg::STEP_P10_CORR: begin
            mul_req.a  = p00_ff;
            mul_req.b  = 33'(k1_ff);
            mul_req.sh = kabf_pkg::SHIFT_GAIN;
         end
         kabf_pkg::STEP_P11_CORR: begin
            mul_req.a  = p01_ff;
            mul_req.b  = 33'(k1_ff);
            mul_req.sh = kabf_pkg::SHIFT_GAIN;
         end
         kabf_pkg::STEP_P00_CORR: begin
            mul_req.a  = p00_ff;
            mul_req.b  = 33'(k0_ff);
            mul_req.sh = kabf_pkg::SHIFT_GAIN;
         end
         kabf_pkg::STEP_P01_CORR: begin
            mul_req.a  = p01_ff;
            mul_req.b  = 33'(k0_ff);
            mul_req.sh = kabf_pkg::SHIFT_GAIN;
         end
         default: mul_req.a = '0;
      endcase
      div_req.start = (state_ff == kabf_pkg::ST_DIV_GO);
      div_req.num   = ksel_ff ? p10_ff : p00_ff;
      div_req.den   = s_cov;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ksel_in      = ksel_ff;
      z_in         = z_ff;
      w_in         = w_ff;
      dt_in        = dt_ff;
      ang_in       = ang_ff;
      bias_in      = bias_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      p10_in       = p10_ff;
      p11_in       = p11_ff;
      inner_in     = inner_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      y_in         = y_ff;
      jump_in      = jump_ff;
      apn_in       = apn_ff;
      bpn_in       = bpn_ff;
      mn_in        = mn_ff;
      wre_in       = wre_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ang_in   = rsp_ang_ff;
      rsp_bias_in  = rsp_bias_ff;
      rsp_jump_in  = rsp_jump_ff;

      if (csr_write_enable) begin
         case (csr_index)
            kabf_pkg::CSR_ANGLE_NOISE: apn_in = csr_write_data;
            kabf_pkg::CSR_BIAS_NOISE:  bpn_in = csr_write_data;
            kabf_pkg::CSR_MEAS_NOISE:  mn_in  = csr_write_data;
            kabf_pkg::CSR_WRAP_EN:     wre_in = csr_write_data[0];
            default:                   wre_in = wre_ff;
         endcase
      end

      case (state_ff)
         kabf_pkg::ST_IDLE: begin
            if (req_valid) begin
               z_in     = req_measured_angle;
               w_in     = req_gyro_rate;
               dt_in    = req_time_step;
               state_in = kabf_pkg::ST_CHECK;
            end
         end
         kabf_pkg::ST_CHECK: begin
            if (wrap_hit) begin
               ang_in   = 32'(z_ff);
               jump_in  = 1'b1;
               state_in = kabf_pkg::ST_FINISH;
            end else begin
               jump_in  = 1'b0;
               step_in  = kabf_pkg::STEP_ANG_PRED;
               state_in = kabf_pkg::ST_MUL_GO;
            end
         end
         kabf_pkg::ST_MUL_GO: state_in = kabf_pkg::ST_MUL_WAIT;
         kabf_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = kabf_pkg::ST_MUL_GO;
               case (step_ff)
                  kabf_pkg::STEP_ANG_PRED: begin
                     ang_in  = kabf_pkg::sat32(50'(ang_ff) + 50'(mul_result));
                     step_in = kabf_pkg::STEP_T;
                  end
                  kabf_pkg::STEP_T: begin
                     // inner term takes the cross terms before they move
                     inner_in = kabf_pkg::sat48(52'(mul_result) - 52'(p01_ff) -
                                                52'(p10_ff) + 52'(nac));
                     p01_in   = kabf_pkg::sat48(52'(p01_ff) - 52'(mul_result));
                     p10_in   = kabf_pkg::sat48(52'(p10_ff) - 52'(mul_result));
                     step_in  = kabf_pkg::STEP_P00_PRED;
                  end
                  kabf_pkg::STEP_P00_PRED: begin
                     p00_in  = kabf_pkg::sat48(52'(p00_ff) + 52'(mul_result));
                     step_in = kabf_pkg::STEP_P11_PRED;
                  end
                  kabf_pkg::STEP_P11_PRED: begin
                     p11_in   = kabf_pkg::sat48(52'(p11_ff) + 52'(mul_result));
                     ksel_in  = 1'b0;
                     state_in = kabf_pkg::ST_DIV_GO;
                  end
                  kabf_pkg::STEP_ANG_CORR: begin
                     ang_in  = kabf_pkg::sat32(50'(ang_ff) + 50'(mul_result));
                     step_in = kabf_pkg::STEP_BIAS_CORR;
                  end
                  kabf_pkg::STEP_BIAS_CORR: begin
                     bias_in = kabf_pkg::sat32(50'(bias_ff) + 50'(mul_result));
                     step_in = kabf_pkg::STEP_P10_CORR;
                  end
                  // cross and bias rows first: they still need the old p00, p01
                  kabf_pkg::STEP_P10_CORR: begin
                     p10_in  = kabf_pkg::sat48(52'(p10_ff) - 52'(mul_result));
                     step_in = kabf_pkg::STEP_P11_CORR;
                  end
                  kabf_pkg::STEP_P11_CORR: begin
                     p11_in  = kabf_pkg::sat48(52'(p11_ff) - 52'(mul_result));
                     step_in = kabf_pkg::STEP_P00_CORR;
                  end
                  kabf_pkg::STEP_P00_CORR: begin
                     p00_in  = kabf_pkg::sat48(52'(p00_ff) - 52'(mul_result));
                     step_in = kabf_pkg::STEP_P01_CORR;
                  end
                  kabf_pkg::STEP_P01_CORR: begin
                     p01_in   = kabf_pkg::sat48(52'(p01_ff) - 52'(mul_result));
                     state_in = kabf_pkg::ST_FINISH;
                  end
                  default: state_in = kabf_pkg::ST_FINISH;
               endcase
            end
         end
         kabf_pkg::ST_DIV_GO: state_in = kabf_pkg::ST_DIV_WAIT;
         kabf_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               if (!ksel_ff) begin
                  k0_in    = div_quot;
                  ksel_in  = 1'b1;
                  state_in = kabf_pkg::ST_DIV_GO;
               end else begin
                  k1_in    = div_quot;
                  y_in     = kabf_pkg::sat32(50'(z_ff) - 50'(ang_ff));
                  step_in  = kabf_pkg::STEP_ANG_CORR;
                  state_in = kabf_pkg::ST_MUL_GO;
               end
            end
         end
         kabf_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ang_in   = ang_ff;
               rsp_bias_in  = bias_ff;
               rsp_jump_in  = jump_ff;
               state_in     = kabf_pkg::ST_IDLE;
            end
         end
         default: state_in = kabf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kabf_pkg::ST_IDLE;
         step_ff      <= kabf_pkg::STEP_ANG_PRED;
         ksel_ff      <= 1'b0;
         ang_ff       <= '0;
         bias_ff      <= '0;
         p00_ff       <= '0;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= '0;
         apn_ff       <= 32'd16777;
         bpn_ff       <= 32'd50332;
         mn_ff        <= 32'd503316;
         wre_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ksel_ff      <= ksel_in;
         ang_ff       <= ang_in;
         bias_ff      <= bias_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
         apn_ff       <= apn_in;
         bpn_ff       <= bpn_in;
         mn_ff        <= mn_in;
         wre_ff       <= wre_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      z_ff        <= z_in;
      w_ff        <= w_in;
      dt_ff       <= dt_in;
      inner_ff    <= inner_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      y_ff        <= y_in;
      jump_ff     <= jump_in;
      rsp_ang_ff  <= rsp_ang_in;
      rsp_bias_ff <= rsp_bias_in;
      rsp_jump_ff <= rsp_jump_in;
   end

   assign req_stall          = (state_ff != kabf_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_angle = rsp_ang_ff;
   assign rsp_estimated_bias = rsp_bias_ff;
   assign rsp_wrap_jump      = rsp_jump_ff;

   // a product only lands while the sequencer waits for it
   a_mul_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == kabf_pkg::ST_MUL_WAIT)
      else $error("multiplier result outside its wait state");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == kabf_pkg::ST_DIV_WAIT)
      else $error("divider result outside its wait state");

   a_check_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == kabf_pkg::ST_CHECK |=>
         state_ff == kabf_pkg::ST_FINISH || state_ff == kabf_pkg::ST_MUL_GO)
      else $error("wrap check left to an unexpected state");

endmodule
`default_nettype wire
